>>> sv/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Shared constants for the k-th smallest select block.
// ----------------------------------------------------------------------------
package kss_pkg;
  localparam int MAX_ELEMENTS = 256;
  localparam int DATA_W       = 32;
  localparam int RANK_W       = 9;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;
endpackage

>>> sv/kss_ram.sv
// ----------------------------------------------------------------------------
// kss_ram
// Single-port synchronous RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module kss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> sv/kth_smallest_select_core.sv
// ----------------------------------------------------------------------------
// kth_smallest_select_core
// Loads signed values into an element store and answers rank queries by
// in-place quickselect over a single-port RAM.
// Load: accepted without a result. Query out of range: result valid the cycle
// after acceptance. Otherwise the result is ready when the partition passes
// end, each compare and move using the single RAM port. One request at a time.
// Reset clears the count and control; the store contents are left as they are.
// ----------------------------------------------------------------------------
module kth_smallest_select_core #(
  parameter int MAX_ELEMENTS = kss_pkg::MAX_ELEMENTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic signed [31:0]         in_value,
  input  logic                       in_first,
  input  logic [kss_pkg::RANK_W-1:0] in_rank,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         out_selected,
  output logic                       out_status
);
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = (CW > kss_pkg::RANK_W) ? CW : kss_pkg::RANK_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PRD   = 10'b0000000010,
    S_PIV   = 10'b0000000100,
    S_JRD   = 10'b0000001000,
    S_JCHK  = 10'b0000010000,
    S_IRD   = 10'b0000100000,
    S_ICHK  = 10'b0001000000,
    S_PUT   = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_LRD   = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [31:0]       piv_r, piv_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic              st_r, st_nxt;

  logic              we;
  logic [AW-1:0]     addr;
  logic [31:0]       wdata, rdata;
  logic [31:0]       rkey, pkey;
  logic [CW-1:0]     cnt_base;
  logic [PW-1:0]     rank_x, count_x;

  kss_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign rkey = rdata ^ 32'h8000_0000;
  assign pkey = piv_r ^ 32'h8000_0000;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_selected = res_r;
  assign out_status   = st_r;
  assign cnt_base = in_first ? '0 : count_r;
  assign rank_x  = PW'(in_rank);
  assign count_x = PW'(count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lo_nxt = lo_r; hi_nxt = hi_r; i_nxt = i_r; j_nxt = j_r; pos_nxt = pos_r;
    piv_nxt = piv_r; res_nxt = res_r; st_nxt = st_r;
    we = 1'b0; addr = i_r; wdata = rdata;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == kss_pkg::KIND_LOAD) begin
            if (cnt_base < CW'(MAX_ELEMENTS)) begin
              we = 1'b1;
              addr = cnt_base[AW-1:0];
              wdata = in_value;
              count_nxt = cnt_base + 1'b1;
            end else begin
              count_nxt = cnt_base;
            end
          end else if (in_rank == '0 || rank_x > count_x) begin
            res_nxt = '0;
            st_nxt = kss_pkg::STATUS_ERR;
            state_nxt = S_OUT;
          end else begin
            st_nxt = kss_pkg::STATUS_OK;
            pos_nxt = AW'(rank_x - 1'b1);
            lo_nxt = '0;
            hi_nxt = AW'(count_r - 1'b1);
            i_nxt = '0;
            j_nxt = AW'(count_r - 1'b1);
            addr = '0;
            state_nxt = S_PRD;
          end
        end
      end
      S_LRD: begin
        addr = lo_r;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        // range start read issued last cycle
        if (lo_r >= hi_r) begin
          res_nxt = rdata;
          state_nxt = S_OUT;
        end else begin
          piv_nxt = rdata;
          i_nxt = lo_r; j_nxt = hi_r;
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        if (i_r == j_r) begin
          state_nxt = S_PUT;
        end else begin
          addr = j_r;
          state_nxt = S_JCHK;
        end
      end
      S_JRD: begin
        addr = j_r;
        state_nxt = S_JCHK;
      end
      S_JCHK: begin
        if (j_r > i_r && rkey >= pkey) begin
          j_nxt = j_r - 1'b1;
          if (j_r - 1'b1 == i_r) begin
            addr = j_r - 1'b1;
            state_nxt = S_IRD;
          end else begin
            addr = j_r - 1'b1;
          end
        end else begin
          we = 1'b1; addr = i_r; wdata = rdata;
          state_nxt = S_IRD;
        end
      end
      S_IRD: begin
        // j == i case: store[i]=store[j] is a no-op; read i now
        addr = i_r;
        state_nxt = S_ICHK;
      end
      S_ICHK: begin
        if (i_r < j_r && rkey <= pkey) begin
          i_nxt = i_r + 1'b1;
          addr = i_r + 1'b1;
        end else begin
          we = 1'b1; addr = j_r; wdata = rdata;
          state_nxt = (i_r == j_r) ? S_PUT : S_JRD;
        end
      end
      S_PUT: begin
        we = 1'b1; addr = i_r; wdata = piv_r;
        if (pos_r == i_r) begin
          res_nxt = piv_r;
          state_nxt = S_OUT;
        end else begin
          if (pos_r < i_r) begin
            hi_nxt = i_r - 1'b1;
          end else begin
            lo_nxt = i_r + 1'b1;
          end
          state_nxt = S_LRD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; i_r <= i_nxt; j_r <= j_nxt; pos_r <= pos_nxt;
    piv_r <= piv_nxt; st_r <= st_nxt;
    res_r <= res_nxt;
  end
endmodule

>>> dv/kth_smallest_select_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kth_smallest_select_core_tb
// Loads sets of signed values and queries ranks, checking each selected value
// and status against an in-testbench quickselect over a mirrored store. Runs
// with and without sender gaps and receiver stalls, including a long output
// hold-off and a full drain between phases.
// ----------------------------------------------------------------------------
module kth_smallest_select_core_tb;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [31:0] selected;
    logic               status;
  } rank_answer_t;

  class kss_scoreboard;
    logic signed [31:0] shadow_store[kss_pkg::MAX_ELEMENTS];
    int                 shadow_count;
    rank_answer_t       pending_answers[$];
    int                 mismatches;
    int                 answers_seen;
    int                 loads;
    int                 queries;
    int                 rank_errors;

    function logic signed [31:0] kth_value(int pos);
      int lo;
      int hi;
      int i;
      int j;
      logic signed [31:0] pivot;
      lo = 0;
      hi = shadow_count - 1;
      while (lo < hi) begin
        i = lo;
        j = hi;
        pivot = shadow_store[lo];
        while (i != j) begin
          while (j > i && shadow_store[j] >= pivot) j--;
          shadow_store[i] = shadow_store[j];
          while (i < j && shadow_store[i] <= pivot) i++;
          shadow_store[j] = shadow_store[i];
        end
        shadow_store[i] = pivot;
        if (pos == i) return pivot;
        if (pos < i) hi = i - 1;
        else lo = i + 1;
      end
      return shadow_store[lo];
    endfunction

    function void note_request(logic kind, logic signed [31:0] value, logic first,
                               logic [kss_pkg::RANK_W-1:0] rank);
      rank_answer_t a;
      if (kind == kss_pkg::KIND_LOAD) begin
        loads++;
        if (first) shadow_count = 0;
        if (shadow_count < kss_pkg::MAX_ELEMENTS) begin
          shadow_store[shadow_count] = value;
          shadow_count++;
        end
      end else begin
        queries++;
        if (rank == 0 || rank > shadow_count) begin
          a.selected = '0;
          a.status   = kss_pkg::STATUS_ERR;
          rank_errors++;
        end else begin
          a.selected = kth_value(int'(rank) - 1);
          a.status   = kss_pkg::STATUS_OK;
        end
        pending_answers.push_back(a);
      end
    endfunction

    function void check_result(logic signed [31:0] selected, logic status);
      rank_answer_t a;
      answers_seen++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: selected %0d status %0d",
                                       selected, status);
        return;
      end
      a = pending_answers.pop_front();
      if (selected !== a.selected || status !== a.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected selected %0d status %0d, got %0d status %0d",
                   a.selected, a.status, selected, status);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_kind;
  logic signed [31:0]            in_value;
  logic                          in_first;
  logic [kss_pkg::RANK_W-1:0]    in_rank;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [31:0]            out_selected;
  logic                          out_status;

  kss_scoreboard        sb;
  int                   send_idle_pct;
  int                   stall_pct;
  int                   hold_cycles;
  longint               cycles;

  kth_smallest_select_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_value    (in_value),
    .in_first    (in_first),
    .in_rank     (in_rank),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_selected(out_selected),
    .out_status  (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("[kth_smallest_select_core] ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_selected, out_status);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_request(logic kind, logic signed [31:0] value, logic first,
                              logic [kss_pkg::RANK_W-1:0] rank);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    in_first <= first;
    in_rank  <= rank;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, value, first, rank);
  endtask

  task automatic load(logic signed [31:0] value, logic first);
    send_request(kss_pkg::KIND_LOAD, value, first, logic'($urandom) ? 9'h1FF : 9'h000);
  endtask

  task automatic query(int rank);
    send_request(kss_pkg::KIND_QUERY, $urandom, logic'($urandom),
                 rank[kss_pkg::RANK_W-1:0]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return $signed(32'($urandom_range(6))) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_sets(int target);
    int sent;
    int n;
    int q;
    int rank;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(39) == 0) n = 32 + $urandom_range(31);
      else n = 1 + $urandom_range(15);
      for (int k = 0; k < n; k++) begin
        load(random_value(), k == 0 && $urandom_range(7) != 0);
        sent++;
        if ($urandom_range(19) == 0) begin
          query($urandom_range(sb.shadow_count + 1));
          sent++;
        end
      end
      q = 1 + $urandom_range(3);
      for (int k = 0; k < q; k++) begin
        case ($urandom_range(9))
          0:       rank = 0;
          1:       rank = 256;
          2:       rank = sb.shadow_count + 1;
          default: rank = 1 + $urandom_range(sb.shadow_count - 1);
        endcase
        query(rank);
      end
      sent += q;
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_kind  <= kss_pkg::KIND_LOAD;
    in_value <= '0;
    in_first <= 1'b0;
    in_rank  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty set, rank extremes, value extremes, ties
    query(1);
    query(0);
    load(32'sh7FFF_FFFF, 1'b1);
    load(32'sh8000_0000, 1'b0);
    load(32'sh0000_0000, 1'b0);
    load(-32'sd1, 1'b0);
    load(32'sh7FFF_FFFF, 1'b0);
    load(-32'sd1, 1'b0);
    for (int r = 0; r <= 7; r++) query(r);
    query(256);
    load(32'sd5, 1'b1);
    query(1);
    query(2);
    drain();

    // long output hold-off fills the block and stalls its input
    hold_cycles = 400;
    for (int k = 0; k < 6; k++) query(1 + k % 2);
    drain();

    // full store, then overflow loads are dropped
    for (int k = 0; k < kss_pkg::MAX_ELEMENTS + 3; k++) load(random_value(), k == 0);
    query(1);
    query(kss_pkg::MAX_ELEMENTS);
    query(kss_pkg::MAX_ELEMENTS / 2);
    query(kss_pkg::MAX_ELEMENTS + 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      random_sets(72);
      drain();
    end
    stall_pct = 0;
    repeat (50) @(posedge clk);

    $display("covered %0d loads and %0d queries (%0d out of range), %0d results checked",
             sb.loads, sb.queries, sb.rank_errors, sb.answers_seen);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
      $display("[kth_smallest_select_core] OK");
    end else begin
      $display("[kth_smallest_select_core] ERROR");
    end
    $finish;
  end
endmodule
